// ----- hw/rtl/bdlp_pkg.sv -----
// bdlp_pkg: shared constants for the button debouncer with long-press reports.
// Holds the configuration register indexes, width and reset values; no dependencies.
`default_nettype none

package bdlp_pkg;

	// Width of the configuration registers and of the config write data
	localparam int CFG_WIDTH = 20;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_DEBOUNCE_TICKS   = 1'b0,
		REG_LONG_PRESS_TICKS = 1'b1
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(100);
	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(1000);

endpackage

`default_nettype wire

// ----- hw/rtl/bdlp_cfg.sv -----
// bdlp_cfg: configuration registers, kept as ready-to-load timer values.
// Saturates to the counter width and maps zero to one; uses bdlp_pkg.
`default_nettype none

module bdlp_cfg #(
	parameter int COUNT_WIDTH = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire bdlp_pkg::cfg_reg_t            cfg_index,
	input  wire logic [bdlp_pkg::CFG_WIDTH-1:0] cfg_data,
	output logic      [COUNT_WIDTH-1:0]        db_load,
	output logic      [COUNT_WIDTH-1:0]        lp_load
);

	localparam int WIDE = (COUNT_WIDTH > bdlp_pkg::CFG_WIDTH) ? COUNT_WIDTH : bdlp_pkg::CFG_WIDTH;
	localparam logic [WIDE-1:0] CNT_MAX = {WIDE{1'b1}} >> (WIDE - COUNT_WIDTH);

	logic [COUNT_WIDTH-1:0] db_load_q;
	logic [COUNT_WIDTH-1:0] lp_load_q;

	// Clamp a register value into the counter range, zero acts as one
	function automatic logic [COUNT_WIDTH-1:0] to_load(input logic [bdlp_pkg::CFG_WIDTH-1:0] r);
		logic [WIDE-1:0] v;
		v = WIDE'(r);
		if (v > CNT_MAX) begin
			v = CNT_MAX;
		end
		if (v == '0) begin
			v = WIDE'(1);
		end
		return v[COUNT_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_load_q <= to_load(bdlp_pkg::DEBOUNCE_RESET);
			lp_load_q <= to_load(bdlp_pkg::LONG_PRESS_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				bdlp_pkg::REG_DEBOUNCE_TICKS:   db_load_q <= to_load(cfg_data);
				bdlp_pkg::REG_LONG_PRESS_TICKS: lp_load_q <= to_load(cfg_data);
				default: ;
			endcase
		end
	end

	assign db_load = db_load_q;
	assign lp_load = lp_load_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bdlp_core.sv -----
// bdlp_core: tick input register and per-button debounce/long-press state.
// Turns one tick into a set of pending reports in one pass; uses bdlp_pkg.
`default_nettype none

module bdlp_core #(
	parameter int BUTTONS     = 3,
	parameter int COUNT_WIDTH = 20
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [BUTTONS-1:0]     in_level,
	input  wire logic [COUNT_WIDTH-1:0] db_load,
	input  wire logic [COUNT_WIDTH-1:0] lp_load,
	input  wire logic                   buf_free,
	output logic                        fire,
	output logic [2*BUTTONS-1:0]        rpt_mask,
	output logic [2*BUTTONS-1:0]        rpt_pressed
);

	logic                   tick_s1_valid;
	logic [BUTTONS-1:0]     level_s1;

	logic [BUTTONS-1:0]     kept_q, prev_q, watch_fall_q, db_act_q, hold_act_q;
	logic [COUNT_WIDTH-1:0] db_cnt_q   [BUTTONS];
	logic [COUNT_WIDTH-1:0] hold_cnt_q [BUTTONS];

	logic [BUTTONS-1:0]     kept_d, watch_fall_d, db_act_d, hold_act_d;
	logic [COUNT_WIDTH-1:0] db_cnt_d   [BUTTONS];
	logic [COUNT_WIDTH-1:0] hold_cnt_d [BUTTONS];

	assign fire     = tick_s1_valid && buf_free;
	assign in_ready = !tick_s1_valid || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1_valid <= 1'b0;
		end else if (in_ready) begin
			tick_s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= in_level;
		end
	end

	// One pass over the buttons; each button is independent
	always_comb begin
		rpt_mask    = '0;
		rpt_pressed = '0;
		for (int i = 0; i < BUTTONS; i++) begin
			kept_d[i]       = kept_q[i];
			watch_fall_d[i] = watch_fall_q[i];
			db_act_d[i]     = db_act_q[i];
			hold_act_d[i]   = hold_act_q[i];
			db_cnt_d[i]     = db_cnt_q[i];
			hold_cnt_d[i]   = hold_cnt_q[i];

			// long-press timer
			if (hold_act_q[i]) begin
				if (hold_cnt_q[i] != '0) begin
					hold_cnt_d[i] = hold_cnt_q[i] - COUNT_WIDTH'(1);
				end
				if (hold_cnt_d[i] == '0) begin
					hold_act_d[i]      = 1'b0;
					rpt_mask[2*i]      = 1'b1;
					rpt_pressed[2*i]   = kept_q[i];
				end
			end

			// debounce countdown and check
			if (db_act_q[i]) begin
				if (db_cnt_q[i] != '0) begin
					db_cnt_d[i] = db_cnt_q[i] - COUNT_WIDTH'(1);
				end
				if (db_cnt_d[i] == '0) begin
					db_act_d[i] = 1'b0;
					if (!kept_q[i] && level_s1[i]) begin
						hold_cnt_d[i]   = lp_load;
						hold_act_d[i]   = 1'b1;
						watch_fall_d[i] = 1'b1;
					end else if (kept_q[i] && !level_s1[i]) begin
						hold_act_d[i]   = 1'b0;
						hold_cnt_d[i]   = '0;
						watch_fall_d[i] = 1'b0;
					end else begin
						db_cnt_d[i] = COUNT_WIDTH'(1);
						db_act_d[i] = 1'b1;
					end
					kept_d[i]          = !kept_q[i];
					rpt_mask[2*i+1]    = 1'b1;
					rpt_pressed[2*i+1] = !kept_q[i];
				end
			end

			// armed edge restarts the countdown
			if (watch_fall_d[i] ? (prev_q[i] && !level_s1[i]) : (!prev_q[i] && level_s1[i])) begin
				db_cnt_d[i] = db_load;
				db_act_d[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q       <= '0;
			prev_q       <= '0;
			watch_fall_q <= '0;
			db_act_q     <= '0;
			hold_act_q   <= '0;
			for (int i = 0; i < BUTTONS; i++) begin
				db_cnt_q[i]   <= '0;
				hold_cnt_q[i] <= '0;
			end
		end else if (fire) begin
			kept_q       <= kept_d;
			prev_q       <= level_s1;
			watch_fall_q <= watch_fall_d;
			db_act_q     <= db_act_d;
			hold_act_q   <= hold_act_d;
			for (int i = 0; i < BUTTONS; i++) begin
				db_cnt_q[i]   <= db_cnt_d[i];
				hold_cnt_q[i] <= hold_cnt_d[i];
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bdlp_drain.sv -----
// bdlp_drain: pending report buffer and output register.
// Sends one report per cycle in slot order while m_tready is high; marks a tick's last.
`default_nettype none

module bdlp_drain #(
	parameter int BUTTONS = 3,
	parameter int ID_W    = 2,
	parameter int DATA_W  = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire logic [2*BUTTONS-1:0] rpt_mask,
	input  wire logic [2*BUTTONS-1:0] rpt_pressed,
	output logic                      buf_free,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [DATA_W-1:0]         m_tdata,
	output logic                      m_tlast
);

	localparam int SLOTS = 2 * BUTTONS;
	localparam int SEL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0]  pend_q;
	logic [SLOTS-1:0]  pressed_q;
	logic [SLOTS-1:0]  pend_rest;
	logic [SEL_W-1:0]  sel;
	logic              load_out;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;

	// Lowest pending slot goes first: button order, long report first
	always_comb begin
		sel       = '0;
		pend_rest = pend_q;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				sel = SEL_W'(k);
			end
		end
		pend_rest[sel] = 1'b0;
	end

	assign load_out = (pend_q != '0) && (!out_valid_q || m_tready);
	assign buf_free = (pend_q == '0) || (load_out && (pend_rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pend_q <= rpt_mask;
			end else if (load_out) begin
				pend_q <= pend_rest;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pressed_q <= rpt_pressed;
		end
		if (load_out) begin
			out_data_q <= DATA_W'({!sel[0], pressed_q[sel], ID_W'(sel >> 1)});
			out_last_q <= (pend_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// A new tick only lands once every report of the previous tick has left
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (pend_q == '0) || (load_out && (pend_rest == '0)))
		else $error("pending reports overwritten by a new tick");

	// A stalled output holds back the pending set
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready && (pend_q != '0) |=> $stable(pend_q))
		else $error("pending reports moved during output stall");

	// Every loaded report is presented on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("loaded report not presented");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/button_debounce_long_press.sv -----
// Button debouncer with long-press reports: one tick in, zero to 2*BUTTONS reports out.
// A tick's first report passes the input reg (loaded as the tick is taken), the report buffer
// and the output reg before it shows on m_tvalid; a report-less tick stops at the input reg.
// Throughput: one tick per cycle when ticks cause no reports; otherwise one report per cycle
// while m_tready is high, set by the single output register draining the report buffer.
// Reset (arst_n low): all buttons released, rising edge armed, timers idle, registers at 100/1000.
`default_nettype none

module button_debounce_long_press #(
	parameter int BUTTONS     = 3,
	parameter int COUNT_WIDTH = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// tick request
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [((BUTTONS+7)/8)*8-1:0]   s_tdata,   // [0] left_level, [1] middle_level, [2] right_level
	// report request
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [(((BUTTONS > 4) ? 3 : 2)+2+7)/8*8-1:0] m_tdata, // button_id, pressed, long_press
	output logic                                m_tlast,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [0:0]                     cfg_index,
	input  wire logic [bdlp_pkg::CFG_WIDTH-1:0] cfg_data
);

	// Report id width: two bits cover the default three buttons
	localparam int ID_W   = (BUTTONS > 4) ? 3 : 2;
	localparam int DATA_W = (ID_W + 2 + 7) / 8 * 8;

	logic [COUNT_WIDTH-1:0] db_load;
	logic [COUNT_WIDTH-1:0] lp_load;
	logic                   buf_free;
	logic                   fire;
	logic [2*BUTTONS-1:0]   rpt_mask;
	logic [2*BUTTONS-1:0]   rpt_pressed;

	// Config registers hold the clamped timer reload values
	bdlp_cfg #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (bdlp_pkg::cfg_reg_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.db_load   (db_load),
		.lp_load   (lp_load)
	);

	// Register the tick and advance every button's state in one pass
	bdlp_core #(
		.BUTTONS     (BUTTONS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_level    (s_tdata[BUTTONS-1:0]),
		.db_load     (db_load),
		.lp_load     (lp_load),
		.buf_free    (buf_free),
		.fire        (fire),
		.rpt_mask    (rpt_mask),
		.rpt_pressed (rpt_pressed)
	);

	// Drain reports one per cycle while m_tready is high; the next tick waits in the input reg
	bdlp_drain #(
		.BUTTONS (BUTTONS),
		.ID_W    (ID_W),
		.DATA_W  (DATA_W)
	) u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.rpt_mask    (rpt_mask),
		.rpt_pressed (rpt_pressed),
		.buf_free    (buf_free),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

`default_nettype wire

// ----- sim/button_debounce_long_press_tb.sv -----
// Self-checking bench for button_debounce_long_press: sends tick requests carrying raw
// button levels and checks every report request against a behavioral debouncer model.
// Depends on bdlp_pkg and the button_debounce_long_press RTL; reads no files.

module button_debounce_long_press_tb;

	localparam int CFG_WIDTH    = bdlp_pkg::CFG_WIDTH;
	localparam int NUM_BUTTONS  = 3;
	localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
	localparam int SETTLE_TICKS = 8;     // a tick with no report may still sit in the input reg
	localparam int HOLD_OFF_LEN = 300;   // long receiver hold-off, enough to back up the input

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [1:0] button_id;
		logic       pressed;
		logic       long_rep;
		logic       is_last;
	} report_t;

	// Directed table: levels are {right, middle, left}. Rows marked typed carry the
	// report read straight off the behavior; the rest are left to the debouncer model.
	typedef struct {
		logic [2:0] levels;
		bit         typed;
		bit         has_rep;
		report_t    rep;
	} tick_row_t;

	typedef struct {
		logic [CFG_WIDTH-1:0] debounce;
		logic [CFG_WIDTH-1:0] hold;
		int                   ticks;
		idle_mode_t           mode;
		bit                   hold_off;
	} timer_phase_t;

	// Directed part runs with debounce 0 (acts as 1) and long press 2
	tick_row_t dir_rows [20] = '{
		'{3'b000, 1'b1, 1'b0, '0},                           // nothing armed, nothing out
		'{3'b001, 1'b1, 1'b0, '0},                           // left rising edge
		'{3'b001, 1'b1, 1'b1, {2'd0, 1'b1, 1'b0, 1'b1}},     // left press confirmed
		'{3'b001, 1'b1, 1'b0, '0},
		'{3'b001, 1'b1, 1'b1, {2'd0, 1'b1, 1'b1, 1'b1}},     // left long press
		'{3'b000, 1'b1, 1'b0, '0},                           // left falling edge
		'{3'b000, 1'b1, 1'b1, {2'd0, 1'b0, 1'b0, 1'b1}},     // left release confirmed
		'{3'b010, 1'b1, 1'b0, '0},                           // middle glitch high
		'{3'b000, 1'b1, 1'b1, {2'd1, 1'b1, 1'b0, 1'b1}},     // repeated check, state still toggles
		'{3'b000, 1'b1, 1'b1, {2'd1, 1'b0, 1'b0, 1'b1}},     // repeat resolves as release
		'{3'b111, 1'b0, 1'b0, '0},                           // all three rise together
		'{3'b111, 1'b0, 1'b0, '0},                           // three presses in one tick
		'{3'b000, 1'b0, 1'b0, '0},                           // all three fall together
		'{3'b000, 1'b0, 1'b0, '0},                           // long + release per button: six reports
		'{3'b100, 1'b0, 1'b0, '0},                           // right rising
		'{3'b000, 1'b0, 1'b0, '0},                           // right repeated check
		'{3'b100, 1'b0, 1'b0, '0},                           // edge during the repeat reloads
		'{3'b100, 1'b0, 1'b0, '0},                           // right press
		'{3'b000, 1'b0, 1'b0, '0},
		'{3'b000, 1'b0, 1'b0, '0}                            // right long and release together
	};

	// Random phases: timer settings, tick count, idling, and one long receiver hold-off
	timer_phase_t phases [7] = '{
		'{20'd0,       20'd0,       60, IDLE_NONE, 1'b0},
		'{20'd3,       20'd7,       70, IDLE_SEND, 1'b0},
		'{20'd2,       20'd4,       70, IDLE_RECV, 1'b0},
		'{20'd5,       20'd12,      70, IDLE_BOTH, 1'b0},
		'{20'd1,       20'hFFFFF,   50, IDLE_NONE, 1'b0},
		'{20'hFFFFF,   20'd1,       20, IDLE_SEND, 1'b0},
		'{20'd1,       20'd2,       80, IDLE_NONE, 1'b1}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [0] left_level, [1] middle_level, [2] right_level
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // [1:0] button_id, [2] pressed, [3] long_press
	logic                 m_tlast;
	logic                 cfg_we;
	logic [0:0]           cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;

	button_debounce_long_press dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Debouncer model state
	logic [CFG_WIDTH-1:0] debounce_reg;
	logic [CFG_WIDTH-1:0] hold_reg;
	logic [NUM_BUTTONS-1:0] kept;
	logic [NUM_BUTTONS-1:0] prev_level;
	logic [NUM_BUTTONS-1:0] watch_fall;
	logic [NUM_BUTTONS-1:0] debounce_on;
	logic [NUM_BUTTONS-1:0] hold_on;
	logic [CFG_WIDTH-1:0]   debounce_cnt [NUM_BUTTONS];
	logic [CFG_WIDTH-1:0]   hold_cnt     [NUM_BUTTONS];

	report_t    tick_reports [$];   // reports caused by the tick just taken
	report_t    pending_reports [$];
	idle_mode_t idle_mode;
	bit         hold_off_req;
	int         mismatches;
	int         ticks_sent;
	int         reports_seen;

	// A zero register behaves as one; widths match, so no saturation is needed
	function automatic logic [CFG_WIDTH-1:0] timer_load(input logic [CFG_WIDTH-1:0] r);
		return (r == '0) ? CFG_WIDTH'(1) : r;
	endfunction

	function automatic void clear_buttons();
		debounce_reg = bdlp_pkg::DEBOUNCE_RESET;
		hold_reg     = bdlp_pkg::LONG_PRESS_RESET;
		kept         = '0;
		prev_level   = '0;
		watch_fall   = '0;
		debounce_on  = '0;
		hold_on      = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			debounce_cnt[b] = '0;
			hold_cnt[b]     = '0;
		end
	endfunction

	// Advance every button by one tick, in button order, and collect its reports
	function automatic void debounce_tick(input logic [2:0] levels);
		tick_reports.delete();
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			logic armed_edge;
			// long-press timer first, so its report leads the button's reports
			if (hold_on[b]) begin
				if (hold_cnt[b] != '0)
					hold_cnt[b]--;
				if (hold_cnt[b] == '0) begin
					hold_on[b] = 1'b0;
					tick_reports.push_back('{2'(b), kept[b], 1'b1, 1'b0});
				end
			end
			// debounce countdown and level check
			if (debounce_on[b]) begin
				if (debounce_cnt[b] != '0)
					debounce_cnt[b]--;
				if (debounce_cnt[b] == '0) begin
					debounce_on[b] = 1'b0;
					if (!kept[b] && levels[b]) begin
						hold_cnt[b]   = timer_load(hold_reg);
						hold_on[b]    = 1'b1;
						watch_fall[b] = 1'b1;
					end else if (kept[b] && !levels[b]) begin
						hold_on[b]    = 1'b0;
						hold_cnt[b]   = '0;
						watch_fall[b] = 1'b0;
					end else begin
						// inconclusive: look again next tick
						debounce_cnt[b] = CFG_WIDTH'(1);
						debounce_on[b]  = 1'b1;
					end
					kept[b] = ~kept[b];
					tick_reports.push_back('{2'(b), kept[b], 1'b0, 1'b0});
				end
			end
			// armed edge, using the arming as just updated
			armed_edge = watch_fall[b] ? (prev_level[b] && !levels[b])
			                           : (!prev_level[b] && levels[b]);
			if (armed_edge) begin
				debounce_cnt[b] = timer_load(debounce_reg);
				debounce_on[b]  = 1'b1;
			end
			prev_level[b] = levels[b];
		end
		if (tick_reports.size() > 0)
			tick_reports[tick_reports.size()-1].is_last = 1'b1;
	endfunction

	// Offer one tick request; in an idling phase the sender may idle at random first
	task automatic offer_tick(input logic [2:0] levels, input bit typed, input bit has_rep,
			input report_t rep);
		int idle_pct;
		idle_pct = (idle_mode == IDLE_SEND) ? 64 : (idle_mode == IDLE_BOTH) ? 38 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, levels};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		debounce_tick(levels);
		if (typed) begin
			// hand-written row: the model must agree, and the row is what gets checked
			if (tick_reports.size() != (has_rep ? 1 : 0) || (has_rep && tick_reports[0] != rep)) begin
				mismatches++;
				$display("%0t: table row levels %b: expected %0d report(s) %h, model gives %0d",
					$time, levels, has_rep, rep, tick_reports.size());
			end
			if (has_rep)
				pending_reports.push_back(rep);
		end else begin
			foreach (tick_reports[k])
				pending_reports.push_back(tick_reports[k]);
		end
	endtask

	// Write the debounce register, then the long-press register, while the block is idle
	task automatic program_timers(input logic [CFG_WIDTH-1:0] debounce,
			input logic [CFG_WIDTH-1:0] hold);
		cfg_we    <= 1'b1;
		cfg_index <= bdlp_pkg::REG_DEBOUNCE_TICKS;
		cfg_data  <= debounce;
		@(posedge clk);
		cfg_index <= bdlp_pkg::REG_LONG_PRESS_TICKS;
		cfg_data  <= hold;
		@(posedge clk);
		cfg_we <= 1'b0;
		debounce_reg = debounce;
		hold_reg     = hold;
	endtask

	// Drain all expected reports, then let any report-less tick clear the pipeline
	task automatic drain_reports();
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Report receiver: random stalls per phase, plus one long hold-off on request
	initial begin
		int stall_left;
		int stall_pct;
		stall_left = 0;
		m_tready   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			stall_pct = (idle_mode == IDLE_RECV) ? 64 : (idle_mode == IDLE_BOTH) ? 38 : 0;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_OFF_LEN;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Compare each accepted report with the oldest one expected, field by field
	always @(posedge clk) begin
		report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected report: expected none, got id %0d pressed %b long %b last %b",
					$time, m_tdata[1:0], m_tdata[2], m_tdata[3], m_tlast);
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[1:0] !== want.button_id) begin
					mismatches++;
					$display("%0t: button_id expected %0d, got %0d", $time, want.button_id, m_tdata[1:0]);
				end
				if (m_tdata[2] !== want.pressed) begin
					mismatches++;
					$display("%0t: pressed expected %b, got %b", $time, want.pressed, m_tdata[2]);
				end
				if (m_tdata[3] !== want.long_rep) begin
					mismatches++;
					$display("%0t: long_press expected %b, got %b", $time, want.long_rep, m_tdata[3]);
				end
				if (m_tlast !== want.is_last) begin
					mismatches++;
					$display("%0t: last expected %b, got %b", $time, want.is_last, m_tlast);
				end
			end
		end
	end

	// Watchdog: give up after a long stretch with no handshake on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles, %0d report(s) outstanding",
			$time, QUIET_LIMIT, pending_reports.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [2:0] steady;
		logic [2:0] levels;
		int         run_left [NUM_BUTTONS];
		int         span;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_we       = 1'b0;
		cfg_index    = bdlp_pkg::REG_DEBOUNCE_TICKS;
		cfg_data     = '0;
		idle_mode    = IDLE_NONE;
		hold_off_req = 1'b0;
		mismatches   = 0;
		ticks_sent   = 0;
		reports_seen = 0;
		steady       = '0;
		for (int b = 0; b < NUM_BUTTONS; b++)
			run_left[b] = 0;
		clear_buttons();

		// hold reset, then release it for good
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_timers('0, CFG_WIDTH'(2));
		foreach (dir_rows[r])
			offer_tick(dir_rows[r].levels, dir_rows[r].typed, dir_rows[r].has_rep, dir_rows[r].rep);
		s_tvalid <= 1'b0;

		foreach (phases[p]) begin
			// sender pauses until every report is in before touching the registers
			drain_reports();
			program_timers(phases[p].debounce, phases[p].hold);
			idle_mode = phases[p].mode;
			if (phases[p].hold_off) begin
				@(negedge clk) hold_off_req = 1'b1;
				@(posedge clk);
			end
			// the longest runs get past debounce and long press, unless the cap of 40 cuts them short
			span = 2 * int'(timer_load(phases[p].debounce)) + int'(timer_load(phases[p].hold)) + 4;
			if (span > 40)
				span = 40;
			repeat (phases[p].ticks) begin
				// steady presses and releases with random length, plus some bounce
				for (int b = 0; b < NUM_BUTTONS; b++) begin
					if (run_left[b] == 0) begin
						steady[b]   = ~steady[b];
						run_left[b] = $urandom_range(1, span);
					end
					run_left[b]--;
					levels[b] = ($urandom_range(0, 99) < 12) ? 1'($urandom_range(0, 1)) : steady[b];
				end
				offer_tick(levels, 1'b0, 1'b0, '0);
			end
			s_tvalid <= 1'b0;
		end

		drain_reports();
		idle_mode = IDLE_NONE;
		$display("Sent %0d ticks over %0d timer settings, checked %0d reports.",
			ticks_sent, $size(phases) + 1, reports_seen);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
